### src/best_fit_bin_packer_assert.svh
// assertion macros shared by the packer
`ifndef BEST_FIT_BIN_PACKER_ASSERT_SVH
`define BEST_FIT_BIN_PACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFBP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packer check failed");

// next-cycle implication, sampled on clk, off during reset
`define BFBP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packer check failed");

`endif

### src/bfbp_pkg.sv
package bfbp_pkg;

    localparam int MAX_BINS = 64;
    localparam int IDX_W    = $clog2(MAX_BINS);
    localparam int CNT_W    = $clog2(MAX_BINS + 1);
    localparam int SIZE_W   = 16;

    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd10;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } stat_t;

endpackage

### src/best_fit_bin_packer.sv
// best-fit bin packer
// input channel: in_valid/in_ready carry one word of item_size, first_item
// and last_item. first_item empties the bin table before the item is placed.
// output channel: out_valid/out_ready carry one result word per input word:
// bin_index, opened_new, bins_used, status (0 placed, 1 oversize, 2 full)
// and set_done, which echoes last_item.
// configuration: cfg_write with cfg_data sets bin_capacity; write only idle.
// one item at a time: the scan reads the bin table one entry a cycle, so an
// item with n open bins goes from acceptance to result through n reads, a
// compare of the last read, scan end and the decision; with no bin open it
// goes through scan end and the decision only.
// the next word is taken only once the result has been registered, so a new
// item is never taken while the last one is still being scanned.
// in_ready returns high once the result has been moved into the output
// register, so the next word is taken while that result still waits.
// a stalled receiver holds the result; the block then waits in its decision
// step and takes no new word until the output register is free.
// reset: bin_capacity returns to 10, no bins are open, no result is pending.
`include "best_fit_bin_packer_assert.svh"

module best_fit_bin_packer
    import bfbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] item_size,
    input  logic        first_item,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  bin_index,
    output logic        opened_new,
    output logic [6:0]  bins_used,
    output logic [1:0]  status,
    output logic        set_done
);

    cmd_t  cmd;
    stat_t stat;

    bfbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfbp_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .item_size  (item_size),
        .first_item (first_item),
        .last_item  (last_item),
        .cmd        (cmd),
        .stat       (stat),
        .bin_index  (bin_index),
        .opened_new (opened_new),
        .bins_used  (bins_used),
        .status     (status),
        .set_done   (set_done)
    );

    `BFBP_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    `BFBP_ASSERT_IMP(a_open_is_placed, out_valid && opened_new, status == ST_PLACED)
    `BFBP_ASSERT_IMP(a_placed_has_bin, out_valid && (status == ST_PLACED), bins_used != 7'd0)
    `BFBP_ASSERT_IMP(a_reject_index, out_valid && (status != ST_PLACED), bin_index == 6'd0)

endmodule

### src/bfbp_ctrl.sv
module bfbp_ctrl
    import bfbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // result register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### src/bfbp_dpath.sv
module bfbp_dpath
    import bfbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic [SIZE_W-1:0] item_size,
    input  logic              first_item,
    input  logic              last_item,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic [5:0]        bin_index,
    output logic              opened_new,
    output logic [6:0]        bins_used,
    output logic [1:0]        status,
    output logic              set_done
);

    logic [SIZE_W-1:0] space_mem [MAX_BINS];
    logic [SIZE_W-1:0] rd_data_reg;

    logic [SIZE_W-1:0] cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  scan_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              found_reg;
    logic [SIZE_W-1:0] best_left_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              last_reg;

    logic [5:0]        bin_index_reg;
    logic              opened_reg;
    logic [6:0]        bins_used_reg;
    logic [1:0]        status_reg;
    logic              set_done_reg;

    logic              rd_en;
    logic [SIZE_W-1:0] left;
    logic              fits;
    logic              oversize;
    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;
    logic [IDX_W-1:0]  dec_idx;
    logic              dec_open;
    logic [1:0]        dec_status;

    assign rd_en          = cmd.scan && (scan_reg < count_reg);
    assign stat.scan_done = (scan_reg == count_reg) && !pend_reg;

    assign fits = rd_data_reg >= size_reg;
    assign left = rd_data_reg - size_reg;

    assign oversize = size_reg > cap_reg;
    assign full     = count_reg == CNT_W'(MAX_BINS);

    always_comb
    begin
        dec_idx    = '0;
        dec_open   = 1'b0;
        dec_status = ST_PLACED;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_data    = cap_reg - size_reg;
        count_next = count_reg;
        if (oversize)
        begin
            dec_status = ST_OVERSIZE;
        end
        else if (found_reg)
        begin
            dec_idx = best_idx_reg;
            wr_en   = cmd.commit;
            wr_addr = best_idx_reg;
            wr_data = best_left_reg;
        end
        else if (full)
        begin
            dec_status = ST_FULL;
        end
        else
        begin
            dec_idx    = count_reg[IDX_W-1:0];
            dec_open   = 1'b1;
            wr_en      = cmd.commit;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            space_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= space_mem[scan_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cap_reg <= cfg_data;
            if (cmd.load)
            begin
                // clear happens even if the item is rejected later
                if (first_item)
                    count_reg <= '0;
                scan_reg  <= '0;
                pend_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                    scan_reg <= scan_reg + CNT_W'(1);
                if (pend_reg && fits)
                    found_reg <= 1'b1;
            end
            else if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg <= item_size;
            last_reg <= last_item;
        end
        if (rd_en)
            pend_idx_reg <= scan_reg[IDX_W-1:0];
        // strict compare keeps the lowest index on a tie
        if (cmd.scan && pend_reg && fits && (!found_reg || left < best_left_reg))
        begin
            best_left_reg <= left;
            best_idx_reg  <= pend_idx_reg;
        end
        if (cmd.commit)
        begin
            bin_index_reg <= 6'(dec_idx);
            opened_reg    <= dec_open;
            bins_used_reg <= 7'(count_next);
            status_reg    <= dec_status;
            set_done_reg  <= last_reg;
        end
    end

    assign bin_index  = bin_index_reg;
    assign opened_new = opened_reg;
    assign bins_used  = bins_used_reg;
    assign status     = status_reg;
    assign set_done   = set_done_reg;

endmodule

### tb/sv/bfbp_placement_checker.sv
module bfbp_placement_checker
    import bfbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [SIZE_W-1:0] item_size,
    input  logic              first_item,
    input  logic              last_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [IDX_W-1:0]  bin_index,
    input  logic              opened_new,
    input  logic [CNT_W-1:0]  bins_used,
    input  logic [1:0]        status,
    input  logic              set_done,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [IDX_W-1:0] bin;
        logic             opened;
        logic [CNT_W-1:0] used;
        logic [1:0]       st;
        logic             done;
    } placement_t;

    logic [SIZE_W-1:0] capacity;
    logic [SIZE_W-1:0] bin_room [MAX_BINS];
    logic [CNT_W-1:0]  bins_open;
    placement_t        placement_q [$];
    int                errors = 0;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic place_item(input logic [SIZE_W-1:0] sz, input logic fi, input logic la,
                              output placement_t p);
        int                j;
        int                win_bin;
        logic              found;
        logic [SIZE_W-1:0] best_room;
        logic [SIZE_W-1:0] room_after;
        if (fi)
            bins_open = '0;
        p = '0;
        p.done = la;
        p.st = ST_PLACED;
        if (sz > capacity)
            p.st = ST_OVERSIZE;
        else
        begin
            found = 1'b0;
            best_room = '0;
            win_bin = 0;
            for (j = 0; j < bins_open; j++)
            begin
                if (bin_room[j] >= sz)
                begin
                    room_after = bin_room[j] - sz;
                    // strict compare keeps the lowest index on a tie
                    if (!found || room_after < best_room)
                    begin
                        found = 1'b1;
                        best_room = room_after;
                        win_bin = j;
                    end
                end
            end
            if (found)
            begin
                bin_room[win_bin] = best_room;
                p.bin = win_bin[IDX_W-1:0];
            end
            else if (bins_open >= MAX_BINS)
                p.st = ST_FULL;
            else
            begin
                bin_room[bins_open[IDX_W-1:0]] = capacity - sz;
                p.bin = bins_open[IDX_W-1:0];
                p.opened = 1'b1;
                bins_open++;
            end
        end
        p.used = bins_open;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            bins_open = '0;
            placement_q.delete();
            pending <= 0;
            fail_count <= errors;
        end
        else
        begin
            // retire before predicting: a word taken now cannot leave now
            if (out_valid && out_ready)
            begin
                if (placement_q.size() == 0)
                    flag_error("result word with nothing expected");
                else
                begin
                    want = placement_q.pop_front();
                    if (bin_index !== want.bin)
                        flag_error($sformatf("bin_index %0d, expected %0d", bin_index, want.bin));
                    if (opened_new !== want.opened)
                        flag_error($sformatf("opened_new %0d, expected %0d",
                                             opened_new, want.opened));
                    if (bins_used !== want.used)
                        flag_error($sformatf("bins_used %0d, expected %0d", bins_used, want.used));
                    if (status !== want.st)
                        flag_error($sformatf("status %0d, expected %0d", status, want.st));
                    if (set_done !== want.done)
                        flag_error($sformatf("set_done %0d, expected %0d", set_done, want.done));
                end
            end
            if (in_valid && in_ready)
            begin
                place_item(item_size, first_item, last_item, want);
                placement_q.push_back(want);
            end
            if (cfg_write)
                capacity = cfg_data;
            pending <= placement_q.size();
            fail_count <= errors;
        end
    end

endmodule

### tb/sv/tb_best_fit_bin_packer.sv
module tb_best_fit_bin_packer;
    import bfbp_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic [SIZE_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [SIZE_W-1:0] item_size;
    logic              first_item;
    logic              last_item;
    logic              out_valid;
    logic              out_ready;
    logic [IDX_W-1:0]  bin_index;
    logic              opened_new;
    logic [CNT_W-1:0]  bins_used;
    logic [1:0]        status;
    logic              set_done;
    int                fail_count;
    int                pending_words;

    logic [SIZE_W-1:0] cap_now = CAP_RESET;
    bit                calm = 1'b0;
    int                words_sent = 0;

    best_fit_bin_packer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_size  (item_size),
        .first_item (first_item),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_index  (bin_index),
        .opened_new (opened_new),
        .bins_used  (bins_used),
        .status     (status),
        .set_done   (set_done)
    );

    bfbp_placement_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_size  (item_size),
        .first_item (first_item),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_index  (bin_index),
        .opened_new (opened_new),
        .bins_used  (bins_used),
        .status     (status),
        .set_done   (set_done),
        .fail_count (fail_count),
        .pending    (pending_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #30000000;
        $display("Test completed with failures");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        int c;
        r = $urandom_range(0, 99);
        c = int'(cap_now);
        if (r < 6)
            return '0;
        if (r < 12)
            return cap_now;
        if (r < 17)
            return (c == 65535) ? SIZE_W'($urandom_range(0, 65535))
                                : SIZE_W'($urandom_range(c + 1, 65535));
        if (r < 45)
            return SIZE_W'($urandom_range(0, c / 4));
        if (r < 75)
            return SIZE_W'($urandom_range(0, c / 2));
        return SIZE_W'($urandom_range(c / 2, c));
    endfunction

    task automatic send_word(input logic [SIZE_W-1:0] sz, input logic fi, input logic la);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        item_size <= sz;
        first_item <= fi;
        last_item <= la;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // a fill set uses items over half the capacity so no two share a bin
    task automatic send_set(input int len, input bit fill);
        int                k;
        int                c;
        logic [SIZE_W-1:0] sz;
        logic              fi;
        logic              la;
        c = int'(cap_now);
        for (k = 0; k < len; k++)
        begin
            sz = fill ? SIZE_W'($urandom_range(c / 2 + 1, c)) : pick_size();
            fi = (k == 0);
            la = (k == len - 1);
            if (!fill && $urandom_range(0, 9) == 0)
            begin
                fi = 1'($urandom_range(0, 1));
                la = 1'($urandom_range(0, 1));
            end
            send_word(sz, fi, la);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data <= value;
        cap_now = value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int stall;
        int run;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        int                phase;
        int                phase_end;
        int                r;
        int                len;
        logic [SIZE_W-1:0] phase_cap [8];

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        item_size = '0;
        first_item = 1'b0;
        last_item = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capacity 10 from reset
        send_word(16'd0, 1'b1, 1'b0);     // zero size with no bin open
        send_word(16'd10, 1'b0, 1'b0);
        send_word(16'd7, 1'b0, 1'b0);
        send_word(16'd7, 1'b0, 1'b0);
        send_word(16'd3, 1'b0, 1'b0);     // equal leftovers, lowest bin wins
        send_word(16'd0, 1'b0, 1'b0);
        send_word(16'd11, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'd11, 1'b1, 1'b0);    // clear, then oversize
        send_word(16'd4, 1'b0, 1'b1);

        // zero capacity: only empty items fit
        write_capacity(16'd0);
        send_word(16'd0, 1'b1, 1'b0);
        send_word(16'd0, 1'b0, 1'b0);
        send_word(16'd1, 1'b0, 1'b1);

        write_capacity(16'hFFFF);
        send_word(16'hFFFF, 1'b1, 1'b0);
        send_word(16'h8000, 1'b0, 1'b0);
        send_word(16'h7FFF, 1'b0, 1'b0);
        send_word(16'd0, 1'b0, 1'b0);
        send_word(16'h5555, 1'b0, 1'b0);
        send_word(16'hAAAA, 1'b0, 1'b1);

        phase_cap[0] = 16'd10;
        phase_cap[1] = 16'd1;
        phase_cap[2] = 16'hFFFF;
        phase_cap[3] = 16'd2;
        phase_cap[4] = 16'd100;
        phase_cap[5] = SIZE_W'($urandom_range(1, 65535));
        phase_cap[6] = SIZE_W'($urandom_range(1, 65535));
        phase_cap[7] = 16'd10;

        for (phase = 0; phase < 8; phase++)
        begin
            write_capacity(phase_cap[phase]);
            phase_end = words_sent + 150;
            // drive the table to full and past it
            if (phase == 1 || phase == 3 || phase == 7)
                send_set(66, 1'b1);
            while (words_sent < phase_end)
            begin
                calm = ($urandom_range(0, 6) == 0);
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 12);
                else if (r < 95)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(41, 80);
                send_set(len, 1'b0);
                if ($urandom_range(0, 19) == 0)
                    drain_results();
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (70) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/bfbp_pkg.sv
src/bfbp_ctrl.sv
src/bfbp_dpath.sv
src/best_fit_bin_packer.sv
tb/sv/bfbp_placement_checker.sv
tb/sv/tb_best_fit_bin_packer.sv
